// ----- design/qdr_pkg.sv -----
`default_nettype none

package qdr_pkg;

    // datagram layout
    localparam int ID_BYTES        = 20;
    localparam int MIN_PAYLOAD     = 32;
    localparam int UDP_HDR         = 8;
    localparam int LEN_OFFSET      = 5;
    localparam int LONG_ID_OFFSET  = 6;
    localparam int SHORT_ID_OFFSET = 1;
    localparam int ID_LEN_MIN      = 8;
    localparam int ID_LEN_MAX      = 20;
    localparam int ID_IDX_W        = $clog2(ID_BYTES);
    localparam int CNT_W           = 6;
    localparam int TOTAL_W         = CNT_W + 1;

    localparam logic [CNT_W-1:0] COUNT_MAX      = '1;
    localparam logic [3:0]       INITIAL_NIBBLE = 4'hC;
    localparam logic [7:0]       ROUTE_MARK     = 8'd1;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_TOO_SHORT    = 2'd1,
        ST_NOT_LOADABLE = 2'd2,
        ST_BAD_LEN      = 2'd3
    } t_status;

    typedef logic [ID_BYTES-1:0][7:0] t_id;

    // per-datagram summary handed from parser to router
    typedef struct packed {
        t_status               status;
        logic [7:0]            first_byte;
        logic [ID_IDX_W-1:0]   id_length;
        t_id                   id;
    } t_desc;

endpackage

`default_nettype wire

// ----- design/qdr_in_if.sv -----
`default_nettype none

interface qdr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ----- design/qdr_out_if.sv -----
`default_nettype none

interface qdr_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        long_header;
    logic        initial_packet;
    logic [4:0]  id_length;
    logic [63:0] id_bytes_high;
    logic [63:0] id_bytes_middle;
    logic [31:0] id_bytes_low;
    logic        route_by_app;
    logic [7:0]  app_number;
    logic [15:0] route_cookie;

    modport source (
        output valid, output status, output long_header, output initial_packet,
        output id_length, output id_bytes_high, output id_bytes_middle,
        output id_bytes_low, output route_by_app, output app_number,
        output route_cookie, input ready
    );
    modport sink (
        input valid, input status, input long_header, input initial_packet,
        input id_length, input id_bytes_high, input id_bytes_middle,
        input id_bytes_low, input route_by_app, input app_number,
        input route_cookie, output ready
    );
endinterface

`default_nettype wire

// ----- design/qdr_front.sv -----
`default_nettype none

module qdr_front import qdr_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    qdr_in_if.sink     i_in,
    input  wire logic  i_full,
    output logic       o_push,
    output t_desc      o_desc
);

    logic [CNT_W-1:0]    r_count, n_count;
    logic [7:0]          r_first, n_first;
    logic [7:0]          r_len, n_len;
    t_id                 r_id, n_id;

    logic                acc;
    logic                active;
    logic [CNT_W-1:0]    p;
    logic [CNT_W-1:0]    long_off;
    logic [CNT_W-1:0]    short_off;
    logic                wr_id;
    logic [ID_IDX_W-1:0] wr_idx;
    logic [7:0]          first_eff;
    logic [7:0]          len_eff;
    logic [TOTAL_W-1:0]  total;
    logic                is_long;
    t_status             status;

    assign i_in.ready = !i_full;
    assign acc        = i_in.valid && !i_full;

    // byte position decode
    always_comb begin
        p         = r_count - CNT_W'(UDP_HDR);
        active    = (r_count != COUNT_MAX) && (r_count >= CNT_W'(UDP_HDR));
        long_off  = p - CNT_W'(LONG_ID_OFFSET);
        short_off = p - CNT_W'(SHORT_ID_OFFSET);
        wr_id     = 1'b0;
        wr_idx    = '0;
        if (active && p != '0) begin
            if (r_first[7]) begin
                wr_id  = (p >= CNT_W'(LONG_ID_OFFSET)) && (long_off < CNT_W'(ID_BYTES));
                wr_idx = long_off[ID_IDX_W-1:0];
            end else begin
                wr_id  = (p >= CNT_W'(SHORT_ID_OFFSET)) && (short_off < CNT_W'(ID_BYTES));
                wr_idx = short_off[ID_IDX_W-1:0];
            end
        end
    end

    // capture values including the current beat
    always_comb begin
        first_eff = (active && p == '0) ? i_in.data_byte : r_first;
        len_eff   = (active && p == CNT_W'(LEN_OFFSET)) ? i_in.data_byte : r_len;
        n_id      = r_id;
        if (acc && wr_id) begin
            n_id[wr_idx] = i_in.data_byte;
        end
    end

    // datagram checks
    always_comb begin
        total   = {1'b0, r_count} + TOTAL_W'(1);
        is_long = first_eff[7];
        if (total < TOTAL_W'(MIN_PAYLOAD)) begin
            status = ST_TOO_SHORT;
        end else if (total < TOTAL_W'(MIN_PAYLOAD + UDP_HDR)) begin
            status = ST_NOT_LOADABLE;
        end else if (is_long && (len_eff < 8'(ID_LEN_MIN) || len_eff > 8'(ID_LEN_MAX))) begin
            status = ST_BAD_LEN;
        end else begin
            status = ST_OK;
        end
        o_desc.status     = status;
        o_desc.first_byte = first_eff;
        o_desc.id_length  = is_long ? len_eff[ID_IDX_W-1:0] : '0;
        o_desc.id         = n_id;
        o_push            = acc && i_in.last_byte;
    end

    // next state of counters and capture registers
    always_comb begin
        n_count = r_count;
        n_first = r_first;
        n_len   = r_len;
        if (acc) begin
            if (i_in.last_byte) begin
                n_count = '0;
                n_first = '0;
                n_len   = '0;
            end else begin
                n_first = first_eff;
                n_len   = len_eff;
                if (r_count != COUNT_MAX) begin
                    n_count = r_count + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_first <= '0;
            r_len   <= '0;
        end else begin
            r_count <= n_count;
            r_first <= n_first;
            r_len   <= n_len;
        end
    end

    // id store holds no reset value
    always_ff @(posedge i_clk) begin
        r_id <= n_id;
    end

    // counter clears after the last beat
    a_count_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_in.last_byte |=> r_count == '0 && r_first == '0 && r_len == '0)
        else $error("byte counter not cleared after last beat");

    // counter holds at saturation
    a_count_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && !i_in.last_byte && r_count == COUNT_MAX |=> r_count == COUNT_MAX)
        else $error("byte counter left saturation");

endmodule

`default_nettype wire

// ----- design/qdr_queue.sv -----
`default_nettype none

module qdr_queue import qdr_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_desc i_desc,
    output logic       o_full,
    output logic       o_valid,
    output t_desc      o_desc,
    input  wire logic  i_pop
);

    t_desc       r_mem [2];
    logic        r_wptr, n_wptr;
    logic        r_rptr, n_rptr;
    logic [1:0]  r_cnt, n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_desc  = r_mem[r_rptr];

    // pointer and fill update
    always_comb begin
        n_wptr = r_wptr ^ i_push;
        n_rptr = r_rptr ^ (i_pop && o_valid);
        n_cnt  = r_cnt + {1'b0, i_push} - {1'b0, i_pop && o_valid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_desc;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("push into full queue");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("queue fill out of range");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> r_wptr == r_rptr)
        else $error("queue pointers disagree with fill");

endmodule

`default_nettype wire

// ----- design/qdr_back.sv -----
`default_nettype none

module qdr_back import qdr_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_desc i_desc,
    output logic       o_pop,
    qdr_out_if.source  o_out
);

    logic        r_valid, n_valid;
    t_status     r_status;
    logic        r_long, r_init;
    logic [4:0]  r_idlen;
    logic [63:0] r_high, r_mid;
    logic [31:0] r_low;
    logic        r_by_app;
    logic [7:0]  r_app;
    logic [15:0] r_cookie;

    logic        ok;
    logic        vis;
    logic        is_long;
    t_id         id;
    logic [15:0] cookie;
    logic        n_by_app;
    logic [7:0]  n_app;
    logic [15:0] n_cookie;
    logic [63:0] n_high, n_mid;
    logic [31:0] n_low;

    assign o_pop   = i_valid && (!r_valid || o_out.ready);
    assign n_valid = o_pop || (r_valid && !o_out.ready);

    // id masking and route choice
    always_comb begin
        ok      = (i_desc.status == ST_OK);
        vis     = ok || (i_desc.status == ST_BAD_LEN);
        is_long = i_desc.first_byte[7];
        for (int i = 0; i < ID_BYTES; i++) begin
            if (!ok || (is_long && ID_IDX_W'(i) >= i_desc.id_length)) begin
                id[i] = 8'd0;
            end else begin
                id[i] = i_desc.id[i];
            end
        end
        cookie   = {id[1], id[2]};
        n_by_app = 1'b0;
        n_app    = 8'd0;
        n_cookie = 16'd0;
        if (ok) begin
            if (id[0] == ROUTE_MARK) begin
                n_cookie = cookie;
                if (cookie == 16'd0) begin
                    n_by_app = 1'b1;
                    n_app    = id[4];
                end
            end else begin
                n_by_app = 1'b1;
            end
        end
        n_high = {id[0], id[1], id[2], id[3], id[4], id[5], id[6], id[7]};
        n_mid  = {id[8], id[9], id[10], id[11], id[12], id[13], id[14], id[15]};
        n_low  = {id[16], id[17], id[18], id[19]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_status <= i_desc.status;
            r_long   <= vis && is_long;
            r_init   <= vis && (i_desc.first_byte[7:4] == INITIAL_NIBBLE);
            r_idlen  <= ok ? i_desc.id_length : 5'd0;
            r_high   <= n_high;
            r_mid    <= n_mid;
            r_low    <= n_low;
            r_by_app <= n_by_app;
            r_app    <= n_app;
            r_cookie <= n_cookie;
        end
    end

    assign o_out.valid           = r_valid;
    assign o_out.status          = r_status;
    assign o_out.long_header     = r_long;
    assign o_out.initial_packet  = r_init;
    assign o_out.id_length       = r_idlen;
    assign o_out.id_bytes_high   = r_high;
    assign o_out.id_bytes_middle = r_mid;
    assign o_out.id_bytes_low    = r_low;
    assign o_out.route_by_app    = r_by_app;
    assign o_out.app_number      = r_app;
    assign o_out.route_cookie    = r_cookie;

    a_err_no_route: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_status != ST_OK |-> !r_by_app && r_app == 8'd0 && r_cookie == 16'd0)
        else $error("routing fields set on failed datagram");

    a_route_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_cookie != 16'd0 |-> !r_by_app && r_app == 8'd0)
        else $error("cookie route mixed with app route");

endmodule

`default_nettype wire

// ----- design/quic_dcid_route_parser.sv -----
`default_nettype none

// each result passes the summary queue, then the result register, before it is offered
// throughput: one beat per cycle unless queue full; one result per cycle while ready
// a two-entry summary queue sits between the byte parser and the route stage
// reset (synchronous, active low) clears the byte counter, queue and output valid
// the connection id store is not reset; it is fully rewritten by every loadable datagram

module quic_dcid_route_parser import qdr_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    qdr_in_if.sink     i_in,
    qdr_out_if.source  o_out
);

    logic  push;
    logic  full;
    logic  q_valid;
    logic  pop;
    t_desc f_desc;
    t_desc q_desc;

    qdr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_desc  (f_desc)
    );

    qdr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (f_desc),
        .o_full  (full),
        .o_valid (q_valid),
        .o_desc  (q_desc),
        .i_pop   (pop)
    );

    qdr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_desc  (q_desc),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire
